// ===== hw/rtl/csp_pkg.sv =====
`timescale 1ns / 1ps
package csp_pkg;

  // Request kinds carried in the input tuser field.
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_EXTRACT = 2'd2;
  localparam logic [1:0] REQ_INSERT  = 2'd3;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [1:0] REG_START_BIT  = 2'd0;
  localparam logic [1:0] REG_BIT_LENGTH = 2'd1;
  localparam logic [1:0] REG_BYTE_ORDER = 2'd2;
  localparam logic [1:0] REG_IS_SIGNED  = 2'd3;

  localparam logic [8:0] START_BIT_RST  = 9'd0;
  localparam logic [6:0] BIT_LENGTH_RST = 7'd8;
  localparam logic       BYTE_ORDER_RST = 1'b1;
  localparam logic       IS_SIGNED_RST  = 1'b0;

  // Operation handed from the sequencer to the field datapath.
  typedef struct packed {
    logic [1:0]  req;
    logic [2:0]  byte_sel;
    logic [7:0]  byte_value;
    logic [63:0] raw;
    logic [5:0]  offset;
    logic [6:0]  length;
    logic        intel;
    logic        sgn;
  } csp_op_t;

  // Reverse the bit order inside each byte; this maps Motorola numbering
  // onto a linear order in which the signal runs upward from its MSB.
  function automatic logic [63:0] byte_bit_rev(input logic [63:0] w);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < 8; k++) begin
        r[8*b + k] = w[8*b + 7 - k];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rev64(input logic [63:0] w);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      r[k] = w[63 - k];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/can_signal_pack_unpack.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake        Payload
// in_      slave      tvalid/tready    tuser: req_type; tdata: byte_index, byte_value, raw_value
// out_     master     tvalid/tready    tuser: status; tdata: signal_value, byte_out
// cfg_     APB slave  psel/penable     start_bit, bit_length, byte_order, is_signed
//
// One item at a time: reads, extracts and rejected items pass the read, calc and done states;
// an in-range byte write adds a write-back state, an insert writes back both frame words in turn
// (only the first if it starts in the last frame word), as the memory has a single write port.
// Reset is synchronous; per-word valid flags make the frame read as zero after it.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the sequencer in its final state until that frees.
module can_signal_pack_unpack #(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [79:0] in_tdata,   // [5:0] byte_index, [13:6] byte_value, [77:14] raw_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // [0] status
  output logic [71:0] out_tdata,  // [63:0] signal_value, [71:64] byte_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import csp_pkg::*;

  localparam int NW = (FRAME_BYTES + 7) / 8;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [3:0] NW4 = 4'(NW);
  localparam logic [9:0] FRAME_BITS = 10'(8 * FRAME_BYTES);
  localparam logic [6:0] FRAME_BYTES7 = 7'(FRAME_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WR0  = 3'd3;
  localparam logic [2:0] S_WR1  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers.
  logic [8:0] start_r;
  logic [6:0] len_r;
  logic       order_r;
  logic       sgn_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_BIT_RST;
      len_r   <= BIT_LENGTH_RST;
      order_r <= BYTE_ORDER_RST;
      sgn_r   <= IS_SIGNED_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_START_BIT:  start_r <= cfg_pwdata[8:0];
        REG_BIT_LENGTH: len_r   <= cfg_pwdata[6:0];
        REG_BYTE_ORDER: order_r <= cfg_pwdata[0];
        REG_IS_SIGNED:  sgn_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_START_BIT:  cfg_prdata = {23'd0, start_r};
      REG_BIT_LENGTH: cfg_prdata = {25'd0, len_r};
      REG_BYTE_ORDER: cfg_prdata = {31'd0, order_r};
      REG_IS_SIGNED:  cfg_prdata = {31'd0, sgn_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Decode of the incoming item.
  logic          in_acc;
  logic [1:0]    in_req;
  logic [5:0]    in_idx;
  logic [8:0]    pos;
  logic [9:0]    pos_end;
  logic          sig_req;
  logic          fits;
  logic          byte_ok;
  logic [2:0]    word_a;
  logic [3:0]    word_b;
  logic          ok_a;
  logic          ok_b;

  assign in_req = in_tuser[1:0];
  assign in_idx = in_tdata[5:0];
  assign sig_req = (in_req == REQ_EXTRACT) || (in_req == REQ_INSERT);

  // Motorola bit numbers are mirrored inside the byte so that the signal
  // occupies a contiguous run that starts at its MSB.
  assign pos = order_r ? start_r : {start_r[8:3], ~start_r[2:0]};
  assign pos_end = {1'b0, pos} + {3'd0, len_r};
  assign fits = (len_r != 7'd0) && (len_r <= 7'd64) && (pos_end <= FRAME_BITS);
  assign byte_ok = {1'b0, in_idx} < FRAME_BYTES7;

  assign word_a = sig_req ? pos[8:6] : in_idx[5:3];
  assign word_b = {1'b0, word_a} + 4'd1;
  assign ok_a = {1'b0, word_a} < NW4;
  assign ok_b = word_b < NW4;

  // Sequencer state.
  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  csp_op_t       op_r;
  logic          fits_r;
  logic          byte_ok_r;
  logic [AW-1:0] addr0_r;
  logic [AW-1:0] addr1_r;
  logic          wr0_en_r;
  logic          wr1_en_r;
  logic [63:0]   sig_r;
  logic [7:0]    bout_r;
  logic          status_r;
  logic [63:0]   new0_r;
  logic [63:0]   new1_r;
  logic          out_valid_r;
  logic [71:0]   out_data_r;
  logic          out_status_r;
  logic          out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: state_nxt = S_CALC;
      S_CALC: state_nxt = wr0_en_r ? S_WR0 : S_DONE;
      S_WR0:  state_nxt = wr1_en_r ? S_WR1 : S_DONE;
      S_WR1:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r.req        <= in_req;
      op_r.byte_sel   <= in_idx[2:0];
      op_r.byte_value <= in_tdata[13:6];
      op_r.raw        <= in_tdata[77:14];
      op_r.offset     <= pos[5:0];
      op_r.length     <= len_r;
      op_r.intel      <= order_r;
      op_r.sgn        <= sgn_r;
      fits_r          <= fits;
      byte_ok_r       <= byte_ok;
      addr0_r         <= ok_a ? word_a[AW-1:0] : '0;
      addr1_r         <= ok_b ? word_b[AW-1:0] : '0;
      wr0_en_r        <= ((in_req == REQ_WRITE) && byte_ok) ||
                         ((in_req == REQ_INSERT) && fits);
      wr1_en_r        <= (in_req == REQ_INSERT) && fits && ok_b;
    end
  end

  // Frame memory and field datapath.
  logic [63:0]   rd_data0;
  logic [63:0]   rd_data1;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [63:0]   mem_wr_data;
  logic [63:0]   fu_sig;
  logic [7:0]    fu_bout;
  logic [63:0]   fu_new0;
  logic [63:0]   fu_new1;

  assign mem_wr_en   = (state_r == S_WR0) || (state_r == S_WR1);
  assign mem_wr_addr = (state_r == S_WR1) ? addr1_r : addr0_r;
  assign mem_wr_data = (state_r == S_WR1) ? new1_r : new0_r;

  csp_frame_mem #(
    .NW (NW),
    .AW (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (state_r == S_READ),
    .rd_addr0 (addr0_r),
    .rd_addr1 (addr1_r),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data)
  );

  csp_field_unit u_field (
    .op    (op_r),
    .word0 (rd_data0),
    .word1 (rd_data1),
    .sig   (fu_sig),
    .bout  (fu_bout),
    .new0  (fu_new0),
    .new1  (fu_new1)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      sig_r    <= ((op_r.req == REQ_EXTRACT) && fits_r) ? fu_sig : '0;
      bout_r   <= ((op_r.req == REQ_READ) && byte_ok_r) ? fu_bout : '0;
      status_r <= ((op_r.req == REQ_EXTRACT) || (op_r.req == REQ_INSERT)) && !fits_r;
      new0_r   <= fu_new0;
      new1_r   <= fu_new1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r   <= {bout_r, sig_r};
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // A bounds failure always comes with an all-zero payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 72'd0)
    else $error("status set with nonzero payload");

  // An accepted item keeps the input side closed on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A result appears only from the final sequencer state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the final state");

  // The second frame word is written back only by a signal insert.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR1 |-> op_r.req == REQ_INSERT && fits_r)
    else $error("second word written by a request other than insert");

endmodule

// ===== hw/rtl/csp_frame_mem.sv =====
`timescale 1ns / 1ps
module csp_frame_mem #(
  parameter int NW = 8,
  parameter int AW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [63:0]   rd_data0,
  output logic [63:0]   rd_data1,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);

  logic [63:0]   mem [NW];
  logic [NW-1:0] vld_r;
  logic [63:0]   q0_r;
  logic [63:0]   q1_r;
  logic          v0_r;
  logic          v1_r;

  // A word that was never written reads as zero, which stands in for the
  // cleared frame after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0_r <= mem[rd_addr0];
      q1_r <= mem[rd_addr1];
      v0_r <= vld_r[rd_addr0];
      v1_r <= vld_r[rd_addr1];
    end
  end

  assign rd_data0 = v0_r ? q0_r : '0;
  assign rd_data1 = v1_r ? q1_r : '0;

endmodule

// ===== hw/rtl/csp_field_unit.sv =====
`timescale 1ns / 1ps
module csp_field_unit (
  input  csp_pkg::csp_op_t op,
  input  logic [63:0]      word0,
  input  logic [63:0]      word1,
  output logic [63:0]      sig,
  output logic [7:0]       bout,
  output logic [63:0]      new0,
  output logic [63:0]      new1
);
  import csp_pkg::*;

  logic [63:0]  mask;
  logic [6:0]   rsh;
  logic [63:0]  lo;
  logic [63:0]  hi;
  logic [127:0] win;
  logic [63:0]  v;
  logic [63:0]  ext;
  logic         top_bit;
  logic [63:0]  fld;
  logic [127:0] m128;
  logic [127:0] f128;
  logic [127:0] n128;
  logic [5:0]   bsh;
  logic [63:0]  bnew;

  assign rsh  = 7'd64 - op.length;
  assign mask = {64{1'b1}} >> rsh;

  assign lo = op.intel ? word0 : byte_bit_rev(word0);
  assign hi = op.intel ? word1 : byte_bit_rev(word1);

  // Extraction: align the two words on the first signal bit.
  assign win = {hi, lo} >> op.offset;
  assign v   = win[63:0] & mask;
  assign ext = op.intel ? v : (rev64(v) >> rsh);

  assign top_bit = |(ext & mask & ~(mask >> 1));
  assign sig = (op.sgn && !mask[63] && top_bit) ? (ext | ~mask) : ext;

  // Insertion: Motorola fields are laid down MSB first in linear order.
  assign fld  = op.intel ? (op.raw & mask) : (rev64(op.raw) >> rsh);
  assign m128 = {64'd0, mask} << op.offset;
  assign f128 = {64'd0, fld} << op.offset;
  assign n128 = ({hi, lo} & ~m128) | f128;

  // Byte access within word0.
  assign bsh  = {op.byte_sel, 3'b000};
  assign bout = 8'(word0 >> bsh);
  assign bnew = (word0 & ~(64'hFF << bsh)) | ({56'd0, op.byte_value} << bsh);

  always_comb begin
    case (op.req)
      REQ_WRITE: begin
        new0 = bnew;
        new1 = word1;
      end
      REQ_INSERT: begin
        new0 = op.intel ? n128[63:0]   : byte_bit_rev(n128[63:0]);
        new1 = op.intel ? n128[127:64] : byte_bit_rev(n128[127:64]);
      end
      default: begin
        new0 = word0;
        new1 = word1;
      end
    endcase
  end

endmodule
